### hw/rtl/lobm_pkg.sv
// Package for the limit order book matcher: shared constants, codes and types.
// No dependencies.
package lobm_pkg;

	localparam int BOOK_DEPTH_DEF = 32;
	localparam int PRICE_BITS_DEF = 24;
	localparam int QTY_BITS_DEF   = 32;
	localparam int TIME_BITS_DEF  = 32;

	localparam int          SUM_BITS = 40;
	localparam logic [39:0] SUM_MAX  = 40'hFF_FFFF_FFFF;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_CLAMP = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_TAKE,
		OP_INS
	} side_op_t;

	typedef struct packed {
		side_op_t op;
		logic     pop;
	} side_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_EMIT,
		ST_TAIL,
		ST_POST,
		ST_FLUSH
	} seq_state_t;

endpackage

### hw/rtl/lobm_ord_if.sv
// Order request channel: valid/ready handshake with the order fields.
// No dependencies.
interface lobm_ord_if #(
	parameter int PW = 24,
	parameter int QW = 32,
	parameter int TW = 32
);
	logic          valid;
	logic          ready;
	logic          req_type;
	logic          is_buy;
	logic [PW-1:0] limit_price;
	logic [QW-1:0] order_qty;
	logic [TW-1:0] timestamp;

	modport source (output valid, req_type, is_buy, limit_price, order_qty, timestamp,
		input ready);
	modport sink (input valid, req_type, is_buy, limit_price, order_qty, timestamp,
		output ready);
endinterface

### hw/rtl/lobm_res_if.sv
// Result channel: valid/ready handshake with top of book, fill and status fields.
// No dependencies.
interface lobm_res_if #(
	parameter int PW = 24,
	parameter int QW = 32,
	parameter int TW = 32
);
	logic          valid;
	logic          ready;
	logic [TW-1:0] event_time;
	logic          ask_present;
	logic [PW-1:0] ask_px;
	logic [39:0]   ask_level_qty;
	logic          bid_present;
	logic [PW-1:0] bid_px;
	logic [39:0]   bid_level_qty;
	logic          fill_present;
	logic [PW-1:0] fill_px;
	logic [QW-1:0] fill_qty;
	logic [1:0]    status;
	logic          last_result;

	modport source (output valid, event_time, ask_present, ask_px, ask_level_qty,
		bid_present, bid_px, bid_level_qty, fill_present, fill_px, fill_qty,
		status, last_result, input ready);
	modport sink (input valid, event_time, ask_present, ask_px, ask_level_qty,
		bid_present, bid_px, bid_level_qty, fill_present, fill_px, fill_qty,
		status, last_result, output ready);
endinterface

### hw/rtl/limit_order_book_matcher_core.sv
// Limit order book matcher: price-time priority book with a sequencer over two cell chains.
// Depends on lobm_pkg, lobm_ord_if, lobm_res_if and lobm_side.
// One order at a time: ord.ready is high only while the sequencer is idle.
// The sequencer waits on the result register.
// Reset clears all entry valid bits, side totals and the sequencer at once.
module limit_order_book_matcher_core #(
	parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF,
	parameter int PRICE_BITS = lobm_pkg::PRICE_BITS_DEF,
	parameter int QTY_BITS   = lobm_pkg::QTY_BITS_DEF,
	parameter int TIME_BITS  = lobm_pkg::TIME_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	lobm_ord_if.sink   ord,
	lobm_res_if.source res
);
	import lobm_pkg::*;

	localparam int LW = QTY_BITS + $clog2(BOOK_DEPTH) + 1;
	localparam int RW = TIME_BITS + 3 * PRICE_BITS + 2 * SUM_BITS + QTY_BITS + 6;

	seq_state_t state_q, state_d;

	logic                  mkt_q, buy_q;
	logic [PRICE_BITS-1:0] price_q, fp_q;
	logic [QTY_BITS-1:0]   qty_q, pend_q;
	logic [TIME_BITS-1:0]  time_q;
	logic [1:0]            st_q;
	logic                  emitted_q;
	logic [SUM_BITS-1:0]   tot_ask_q, tot_bid_q;
	logic                  hold_v_q, out_v_q;
	logic [RW-1:0]         hold_q, out_q;

	side_ctl_t             ask_ctl, bid_ctl;
	logic                  a_v, b_v, a_sv, b_sv, a_full, b_full;
	logic [PRICE_BITS-1:0] a_p, b_p, a_sp, b_sp;
	logic [QTY_BITS-1:0]   a_q, b_q;
	logic [LW-1:0]         a_l, b_l;

	logic                  oh_v, oh_sv, own_v, own_full, cross_fail, stop, pop, lvl_empty;
	logic [PRICE_BITS-1:0] oh_p, oh_sp, own_p;
	logic [QTY_BITS-1:0]   oh_q, take;
	logic [SUM_BITS-1:0]   in_opp_tot;
	logic                  improves, lim_rest, out_free, can_cap;
	logic                  accept, do_take, do_ins, cap, cap_fill, flush_move;
	logic [1:0]            cap_st;
	logic [SUM_BITS-1:0]   a_sat, b_sat;
	logic [RW-1:0]         snap;

	lobm_side #(.DEPTH(BOOK_DEPTH), .PW(PRICE_BITS), .QW(QTY_BITS), .LW(LW),
		.IS_BUY(1'b0)) u_ask (
		.clk, .arst_n, .ctl(ask_ctl), .take, .ins_price(price_q), .ins_qty(qty_q),
		.head_v(a_v), .head_price(a_p), .head_qty(a_q), .head_ltot(a_l),
		.sec_v(a_sv), .sec_price(a_sp), .full(a_full)
	);

	lobm_side #(.DEPTH(BOOK_DEPTH), .PW(PRICE_BITS), .QW(QTY_BITS), .LW(LW),
		.IS_BUY(1'b1)) u_bid (
		.clk, .arst_n, .ctl(bid_ctl), .take, .ins_price(price_q), .ins_qty(qty_q),
		.head_v(b_v), .head_price(b_p), .head_qty(b_q), .head_ltot(b_l),
		.sec_v(b_sv), .sec_price(b_sp), .full(b_full)
	);

	always_comb begin
		oh_v     = buy_q ? a_v  : b_v;
		oh_p     = buy_q ? a_p  : b_p;
		oh_q     = buy_q ? a_q  : b_q;
		oh_sv    = buy_q ? a_sv : b_sv;
		oh_sp    = buy_q ? a_sp : b_sp;
		own_v    = buy_q ? b_v : a_v;
		own_p    = buy_q ? b_p : a_p;
		own_full = buy_q ? b_full : a_full;
		in_opp_tot = ord.is_buy ? tot_ask_q : tot_bid_q;
		cross_fail = !mkt_q && (buy_q ? (oh_p > price_q) : (oh_p < price_q));
		stop       = (qty_q == '0) || !oh_v || cross_fail;
		take       = (oh_q < qty_q) ? oh_q : qty_q;
		pop        = (take == oh_q);
		lvl_empty  = !oh_sv || (oh_sp != oh_p);
		improves   = !own_v || (buy_q ? (price_q >= own_p) : (price_q <= own_p));
		lim_rest   = !mkt_q && (qty_q != '0);
		out_free   = !out_v_q || res.ready;
		can_cap    = !hold_v_q || out_free;
		a_sat = (64'(a_l) > 64'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(a_l);
		b_sat = (64'(b_l) > 64'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(b_l);
	end

	always_comb begin
		accept     = 1'b0;
		do_take    = 1'b0;
		do_ins     = 1'b0;
		cap        = 1'b0;
		cap_fill   = 1'b0;
		cap_st     = st_q;
		flush_move = 1'b0;
		unique case (state_q)
			ST_IDLE:  accept = ord.valid;
			ST_MATCH: do_take = !stop;
			ST_EMIT: begin
				cap      = can_cap;
				cap_fill = 1'b1;
			end
			ST_TAIL: begin
				if (lim_rest) begin
					if (own_full) begin
						cap      = can_cap;
						cap_fill = (pend_q != '0);
						cap_st   = STATUS_FULL;
					end else begin
						do_ins = 1'b1;
					end
				end else if (pend_q != '0) begin
					cap      = can_cap;
					cap_fill = 1'b1;
				end else if (mkt_q && !emitted_q) begin
					cap = can_cap;
				end
			end
			ST_POST: begin
				cap      = can_cap;
				cap_fill = (pend_q != '0);
			end
			ST_FLUSH: flush_move = hold_v_q && out_free;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_MATCH;
			ST_MATCH: begin
				if (stop) state_d = ST_TAIL;
				else if (pop && lvl_empty) state_d = ST_EMIT;
			end
			ST_EMIT: if (cap) state_d = ST_MATCH;
			ST_TAIL: begin
				if (lim_rest) begin
					if (own_full) begin
						if (cap) state_d = ST_FLUSH;
					end else begin
						state_d = (improves || pend_q != '0) ? ST_POST : ST_FLUSH;
					end
				end else if (pend_q != '0 || (mkt_q && !emitted_q)) begin
					if (cap) state_d = ST_FLUSH;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_POST:  if (cap) state_d = ST_FLUSH;
			ST_FLUSH: if (!hold_v_q || flush_move) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ask_ctl = '{op: OP_IDLE, pop: 1'b0};
		bid_ctl = '{op: OP_IDLE, pop: 1'b0};
		if (do_take) begin
			if (buy_q) ask_ctl = '{op: OP_TAKE, pop: pop};
			else       bid_ctl = '{op: OP_TAKE, pop: pop};
		end else if (do_ins) begin
			if (buy_q) bid_ctl = '{op: OP_INS, pop: 1'b0};
			else       ask_ctl = '{op: OP_INS, pop: 1'b0};
		end
	end

	assign snap = {time_q,
		a_v, (a_v ? a_p : '0), (a_v ? a_sat : '0),
		b_v, (b_v ? b_p : '0), (b_v ? b_sat : '0),
		cap_fill, (cap_fill ? fp_q : '0), (cap_fill ? pend_q : '0),
		cap_st, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hold_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
			emitted_q <= 1'b0;
			tot_ask_q <= '0;
			tot_bid_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) emitted_q <= 1'b0;
			else if (cap) emitted_q <= 1'b1;
			if (cap) hold_v_q <= 1'b1;
			else if (flush_move) hold_v_q <= 1'b0;
			if ((cap && hold_v_q) || flush_move) out_v_q <= 1'b1;
			else if (res.ready) out_v_q <= 1'b0;
			if (do_take) begin
				if (buy_q) tot_ask_q <= (SUM_BITS'(take) > tot_ask_q) ? '0 :
					tot_ask_q - SUM_BITS'(take);
				else tot_bid_q <= (SUM_BITS'(take) > tot_bid_q) ? '0 :
					tot_bid_q - SUM_BITS'(take);
			end else if (do_ins) begin
				if (buy_q) tot_bid_q <= (65'(tot_bid_q) + 65'(qty_q) > 65'(SUM_MAX)) ?
					SUM_MAX : SUM_BITS'(65'(tot_bid_q) + 65'(qty_q));
				else tot_ask_q <= (65'(tot_ask_q) + 65'(qty_q) > 65'(SUM_MAX)) ?
					SUM_MAX : SUM_BITS'(65'(tot_ask_q) + 65'(qty_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mkt_q   <= ord.req_type;
			buy_q   <= ord.is_buy;
			price_q <= ord.limit_price;
			time_q  <= ord.timestamp;
			pend_q  <= '0;
			fp_q    <= '0;
			if (ord.req_type && (64'(ord.order_qty) > 64'(in_opp_tot))) begin
				qty_q <= QTY_BITS'(in_opp_tot);
				st_q  <= STATUS_CLAMP;
			end else begin
				qty_q <= ord.order_qty;
				st_q  <= STATUS_OK;
			end
		end else if (do_take) begin
			qty_q  <= qty_q - take;
			pend_q <= pend_q + take;
			fp_q   <= oh_p;
		end else if (cap && cap_fill) begin
			pend_q <= '0;
		end
		if (cap) begin
			hold_q <= snap;
			if (hold_v_q) out_q <= hold_q;
		end else if (flush_move) begin
			out_q <= {hold_q[RW-1:1], 1'b1};
		end
	end

	assign ord.ready = (state_q == ST_IDLE);
	assign res.valid = out_v_q;
	assign {res.event_time, res.ask_present, res.ask_px, res.ask_level_qty,
		res.bid_present, res.bid_px, res.bid_level_qty,
		res.fill_present, res.fill_px, res.fill_qty,
		res.status, res.last_result} = out_q;

	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ord.ready |-> !hold_v_q)
		else $error("result held while idle");

	a_not_crossed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && a_v && b_v) |-> (b_p < a_p))
		else $error("book crossed at rest");

	a_emit_has_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (pend_q != '0))
		else $error("emptied level without traded quantity");
endmodule

### hw/rtl/lobm_cell.sv
// One book entry of a sorted side chain: price, quantity and level total.
// Depends on lobm_pkg.
module lobm_cell #(
	parameter int PW      = 24,
	parameter int QW      = 32,
	parameter int LW      = 38,
	parameter bit IS_BUY  = 1'b1,
	parameter bit IS_HEAD = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lobm_pkg::side_ctl_t ctl,
	input  logic [QW-1:0]      take,
	input  logic [PW-1:0]      ins_price,
	input  logic [QW-1:0]      ins_qty,
	input  logic [PW-1:0]      head_price,
	input  logic               prev_v,
	input  logic               prev_keep,
	input  logic [PW-1:0]      prev_price,
	input  logic [QW-1:0]      prev_qty,
	input  logic [LW-1:0]      prev_ltot,
	input  logic               next_v,
	input  logic [PW-1:0]      next_price,
	input  logic [QW-1:0]      next_qty,
	input  logic [LW-1:0]      next_ltot,
	output logic               v,
	output logic [PW-1:0]      price,
	output logic [QW-1:0]      qty,
	output logic [LW-1:0]      ltot,
	output logic               keep
);
	import lobm_pkg::*;

	logic          v_q, v_d;
	logic [PW-1:0] price_q, price_d;
	logic [QW-1:0] qty_q, qty_d;
	logic [LW-1:0] ltot_q, ltot_d;
	logic [LW-1:0] dec, ndec;

	always_comb begin
		keep = v_q && (IS_BUY ? (price_q >= ins_price) : (price_q <= ins_price));
		dec  = (v_q && price_q == head_price) ? LW'(take) : '0;
		ndec = (next_v && next_price == head_price) ? LW'(take) : '0;
		v_d     = v_q;
		price_d = price_q;
		qty_d   = qty_q;
		ltot_d  = ltot_q;
		unique case (ctl.op)
			OP_TAKE: begin
				if (ctl.pop) begin
					v_d     = next_v;
					price_d = next_price;
					qty_d   = next_qty;
					ltot_d  = next_ltot - ndec;
				end else begin
					if (IS_HEAD) qty_d = qty_q - take;
					ltot_d = ltot_q - dec;
				end
			end
			OP_INS: begin
				if (keep) begin
					if (price_q == ins_price) ltot_d = ltot_q + LW'(ins_qty);
				end else if (IS_HEAD || prev_keep) begin
					v_d     = 1'b1;
					price_d = ins_price;
					qty_d   = ins_qty;
					ltot_d  = (prev_keep && prev_price == ins_price) ?
						prev_ltot + LW'(ins_qty) : LW'(ins_qty);
				end else begin
					v_d     = prev_v;
					price_d = prev_price;
					qty_d   = prev_qty;
					ltot_d  = prev_ltot;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		price_q <= price_d;
		qty_q   <= qty_d;
		ltot_q  <= ltot_d;
	end

	assign v     = v_q;
	assign price = price_q;
	assign qty   = qty_q;
	assign ltot  = ltot_q;
endmodule

### hw/rtl/lobm_side.sv
// One side of the book: a chain of cells kept in price-time priority order.
// Depends on lobm_pkg and lobm_cell.
module lobm_side #(
	parameter int DEPTH  = 32,
	parameter int PW     = 24,
	parameter int QW     = 32,
	parameter int LW     = 38,
	parameter bit IS_BUY = 1'b1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lobm_pkg::side_ctl_t ctl,
	input  logic [QW-1:0]       take,
	input  logic [PW-1:0]       ins_price,
	input  logic [QW-1:0]       ins_qty,
	output logic                head_v,
	output logic [PW-1:0]       head_price,
	output logic [QW-1:0]       head_qty,
	output logic [LW-1:0]       head_ltot,
	output logic                sec_v,
	output logic [PW-1:0]       sec_price,
	output logic                full
);
	import lobm_pkg::*;

	logic          v    [DEPTH+1];
	logic [PW-1:0] pr   [DEPTH+1];
	logic [QW-1:0] qt   [DEPTH+1];
	logic [LW-1:0] lt   [DEPTH+1];
	logic          kp   [DEPTH];

	assign v[DEPTH]  = 1'b0;
	assign pr[DEPTH] = '0;
	assign qt[DEPTH] = '0;
	assign lt[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			lobm_cell #(.PW(PW), .QW(QW), .LW(LW), .IS_BUY(IS_BUY), .IS_HEAD(1'b1)) u_cell (
				.clk, .arst_n, .ctl, .take, .ins_price, .ins_qty,
				.head_price(pr[0]),
				.prev_v(1'b0), .prev_keep(1'b0), .prev_price('0), .prev_qty('0),
				.prev_ltot('0),
				.next_v(v[1]), .next_price(pr[1]), .next_qty(qt[1]), .next_ltot(lt[1]),
				.v(v[0]), .price(pr[0]), .qty(qt[0]), .ltot(lt[0]), .keep(kp[0])
			);
		end else begin : g_body
			lobm_cell #(.PW(PW), .QW(QW), .LW(LW), .IS_BUY(IS_BUY), .IS_HEAD(1'b0)) u_cell (
				.clk, .arst_n, .ctl, .take, .ins_price, .ins_qty,
				.head_price(pr[0]),
				.prev_v(v[i-1]), .prev_keep(kp[i-1]), .prev_price(pr[i-1]),
				.prev_qty(qt[i-1]), .prev_ltot(lt[i-1]),
				.next_v(v[i+1]), .next_price(pr[i+1]), .next_qty(qt[i+1]),
				.next_ltot(lt[i+1]),
				.v(v[i]), .price(pr[i]), .qty(qt[i]), .ltot(lt[i]), .keep(kp[i])
			);
		end
	end

	assign head_v     = v[0];
	assign head_price = pr[0];
	assign head_qty   = qt[0];
	assign head_ltot  = lt[0];
	assign sec_v      = v[1];
	assign sec_price  = pr[1];
	assign full       = v[DEPTH-1];
endmodule
